>>> sv/plex_pkg.sv
// Shared types, token kind codes and the keyword table of the lexer.
package plex_pkg;

    localparam logic [5:0] K_EOF   = 6'd0;
    localparam logic [5:0] K_ERR   = 6'd1;
    localparam logic [5:0] K_NUM   = 6'd2;
    localparam logic [5:0] K_IDENT = 6'd3;
    localparam logic [5:0] K_STR   = 6'd4;
    localparam logic [5:0] K_CHR   = 6'd5;
    localparam logic [5:0] K_DOT   = 6'd6;
    localparam logic [5:0] K_PLUS  = 6'd7;
    localparam logic [5:0] K_MINUS = 6'd8;
    localparam logic [5:0] K_STAR  = 6'd9;
    localparam logic [5:0] K_SLASH = 6'd10;
    localparam logic [5:0] K_EQ    = 6'd11;
    localparam logic [5:0] K_COMMA = 6'd12;
    localparam logic [5:0] K_SEMI  = 6'd13;
    localparam logic [5:0] K_LPAR  = 6'd14;
    localparam logic [5:0] K_RPAR  = 6'd15;
    localparam logic [5:0] K_LBRK  = 6'd16;
    localparam logic [5:0] K_RBRK  = 6'd17;
    localparam logic [5:0] K_RBRC  = 6'd18;
    localparam logic [5:0] K_LEQ   = 6'd19;
    localparam logic [5:0] K_NEQ   = 6'd20;
    localparam logic [5:0] K_LT    = 6'd21;
    localparam logic [5:0] K_ASGN  = 6'd22;
    localparam logic [5:0] K_COLON = 6'd23;
    localparam logic [5:0] K_GEQ   = 6'd24;
    localparam logic [5:0] K_GT    = 6'd25;
    localparam logic [5:0] K_KW0   = 6'd26;

    localparam int NUM_KW = 22;

    // Keyword text is right-aligned: the first character sits highest.
    localparam logic [71:0] KW_TEXT [NUM_KW] = '{
        72'("array"), 72'("begin"), 72'("char"), 72'("const"), 72'("do"),
        72'("downto"), 72'("else"), 72'("end"), 72'("for"), 72'("function"),
        72'("if"), 72'("integer"), 72'("uinteger"), 72'("of"),
        72'("procedure"), 72'("read"), 72'("repeat"), 72'("then"), 72'("to"),
        72'("until"), 72'("var"), 72'("write")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd5, 4'd4, 4'd5, 4'd2, 4'd6, 4'd4, 4'd3, 4'd3, 4'd8, 4'd2,
        4'd7, 4'd8, 4'd2, 4'd9, 4'd4, 4'd6, 4'd4, 4'd2, 4'd5, 4'd3, 4'd5
    };

    typedef enum logic [8:0] {
        SC_START = 9'b000000001,
        SC_CMT   = 9'b000000010,
        SC_STR   = 9'b000000100,
        SC_CHR   = 9'b000001000,
        SC_NUM   = 9'b000010000,
        SC_IDENT = 9'b000100000,
        SC_LT    = 9'b001000000,
        SC_COLON = 9'b010000000,
        SC_GT    = 9'b100000000
    } scan_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_RD   = 5'b00100,
        ST_WT   = 5'b01000,
        ST_OUT  = 5'b10000
    } fsm_t;

    // Character of keyword k at position p, or zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [5:0] p);
        int sh;
        sh = int'(KW_LEN[k]) - 1 - int'(p);
        if (sh < 0) begin
            return 8'd0;
        end
        return KW_TEXT[k][8*sh +: 8];
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h2E:   return K_DOT;
            8'h2B:   return K_PLUS;
            8'h2D:   return K_MINUS;
            8'h2A:   return K_STAR;
            8'h2F:   return K_SLASH;
            8'h3D:   return K_EQ;
            8'h2C:   return K_COMMA;
            8'h3B:   return K_SEMI;
            8'h28:   return K_LPAR;
            8'h29:   return K_RPAR;
            8'h5B:   return K_LBRK;
            8'h5D:   return K_RBRK;
            8'h7D:   return K_RBRC;
            default: return K_ERR;
        endcase
    endfunction

endpackage

>>> sv/pascal_subset_lexer_unit.sv
// Top level of the Pascal subset lexer: scan sequencer, token buffer and output beat.
// One source byte enters per beat; the block takes the next byte only after it has
// scanned this one and delivered every token it completes. Each completed token is read
// back from the token buffer RAM one character at a time, each output beat passing
// through a RAM read, a data capture and a handshake that waits for the sink to be
// ready; a byte that ends a token without belonging to it is then scanned again.
// Keyword detection runs alongside the buffer writes, so it costs nothing.
module pascal_subset_lexer_unit
    import plex_pkg::*;
#(
    parameter int MAX_TOKEN = 32,
    parameter int LINE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // char_code
    input  logic                 s_tlast,   // end_of_input
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // line_number, text_char, char_valid, truncated (zero filled to whole bytes)
    output logic [((LINE_BITS+10+7)/8)*8-1:0] m_tdata,
    output logic [5:0]           m_tuser,   // token_kind
    output logic                 m_tlast    // last
);
    localparam int AW = $clog2(MAX_TOKEN);
    localparam int LW = $clog2(MAX_TOKEN + 1);
    localparam int DW = ((LINE_BITS + 10 + 7) / 8) * 8;

    fsm_t                  fsm_reg, fsm_next;
    scan_t                 sc_reg, sc_next;
    logic [LW-1:0]         len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [NUM_KW-1:0]     match_reg, match_next;
    logic [LINE_BITS-1:0]  line_reg;
    logic [7:0]            c_reg;
    logic                  eof_reg;
    logic                  rescan_reg, rescan_next;
    logic [5:0]            kind_reg, kind_next;
    logic [AW-1:0]         idx_reg;
    logic                  out_valid_reg;
    logic [5:0]            o_kind_reg;
    logic [LINE_BITS-1:0]  o_line_reg;
    logic [7:0]            o_char_reg;
    logic                  o_cv_reg, o_tr_reg, o_last_reg;

    logic [7:0] rdata;
    logic       save, emit, clr;
    logic [5:0] kw_kind;
    logic       is_dig, is_alp, is_spc, is_prn;
    logic       cur_last;

    plex_ram #(.WIDTH(8), .DEPTH(MAX_TOKEN)) u_buf (
        .aclk  (aclk),
        .we    (fsm_reg == ST_STEP && save && len_reg < LW'(MAX_TOKEN)),
        .waddr (len_reg[AW-1:0]),
        .wdata (c_reg),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign is_dig = c_reg >= 8'h30 && c_reg <= 8'h39;
    assign is_alp = (c_reg >= 8'h61 && c_reg <= 8'h7A) || (c_reg >= 8'h41 && c_reg <= 8'h5A);
    assign is_spc = c_reg == 8'h20 || (c_reg >= 8'd9 && c_reg <= 8'd13);
    assign is_prn = c_reg >= 8'h20 && c_reg <= 8'h7E;

    // An identifier is a keyword when its text matched all the way, the lengths agree and nothing was truncated.
    always_comb begin
        kw_kind = K_IDENT;
        if (!ovf_reg) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (match_reg[k] && LW'(KW_LEN[k]) == len_reg) begin
                    kw_kind = K_KW0 + 6'(k);
                end
            end
        end
    end

    // One scan step on the held byte.
    always_comb begin
        save = 1'b0;
        emit = 1'b0;
        clr = 1'b0;
        sc_next = sc_reg;
        kind_next = kind_reg;
        rescan_next = 1'b0;
        case (sc_reg)
            SC_CMT: begin
                if (eof_reg) begin
                    clr = 1'b1; emit = 1'b1; kind_next = K_EOF;
                end else if (c_reg == 8'h7D) begin
                    sc_next = SC_START;
                end
            end
            SC_STR: begin
                if (eof_reg) begin
                    clr = 1'b1; emit = 1'b1; kind_next = K_EOF;
                end else if (c_reg == 8'h22) begin
                    emit = 1'b1; kind_next = K_STR;
                end else if (is_prn) begin
                    save = 1'b1;
                end else begin
                    save = 1'b1; emit = 1'b1; kind_next = K_ERR;
                end
            end
            SC_CHR: begin
                if (eof_reg) begin
                    clr = 1'b1; emit = 1'b1; kind_next = K_EOF;
                end else if (c_reg == 8'h27) begin
                    emit = 1'b1; kind_next = K_CHR;
                end else begin
                    save = 1'b1;
                end
            end
            SC_NUM: begin
                if (!eof_reg && is_dig) begin
                    save = 1'b1;
                end else begin
                    emit = 1'b1; kind_next = K_NUM; rescan_next = 1'b1;
                end
            end
            SC_IDENT: begin
                if (!eof_reg && (is_dig || is_alp)) begin
                    save = 1'b1;
                end else begin
                    emit = 1'b1; kind_next = kw_kind; rescan_next = 1'b1;
                end
            end
            SC_LT: begin
                if (!eof_reg && c_reg == 8'h3D) begin
                    save = 1'b1; emit = 1'b1; kind_next = K_LEQ;
                end else if (!eof_reg && c_reg == 8'h3E) begin
                    save = 1'b1; emit = 1'b1; kind_next = K_NEQ;
                end else begin
                    emit = 1'b1; kind_next = K_LT; rescan_next = 1'b1;
                end
            end
            SC_COLON: begin
                if (!eof_reg && c_reg == 8'h3D) begin
                    save = 1'b1; emit = 1'b1; kind_next = K_ASGN;
                end else begin
                    emit = 1'b1; kind_next = K_COLON; rescan_next = 1'b1;
                end
            end
            SC_GT: begin
                if (!eof_reg && c_reg == 8'h3D) begin
                    save = 1'b1; emit = 1'b1; kind_next = K_GEQ;
                end else begin
                    emit = 1'b1; kind_next = K_GT; rescan_next = 1'b1;
                end
            end
            default: begin
                if (eof_reg) begin
                    clr = 1'b1; emit = 1'b1; kind_next = K_EOF;
                end else if (is_spc) begin
                    sc_next = SC_START;
                end else if (is_dig) begin
                    save = 1'b1; sc_next = SC_NUM;
                end else if (c_reg == 8'h22) begin
                    sc_next = SC_STR;
                end else if (c_reg == 8'h27) begin
                    sc_next = SC_CHR;
                end else if (c_reg == 8'h7B) begin
                    sc_next = SC_CMT;
                end else if (is_alp) begin
                    save = 1'b1; sc_next = SC_IDENT;
                end else if (c_reg == 8'h3A) begin
                    save = 1'b1; sc_next = SC_COLON;
                end else if (c_reg == 8'h3E) begin
                    save = 1'b1; sc_next = SC_GT;
                end else if (c_reg == 8'h3C) begin
                    save = 1'b1; sc_next = SC_LT;
                end else begin
                    save = 1'b1; emit = 1'b1; kind_next = single_kind(c_reg);
                end
            end
        endcase
        if (emit) begin
            sc_next = SC_START;
        end
    end

    // Buffer length, overflow and the keyword match vector after the step.
    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        match_next = match_reg;
        if (clr) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (save) begin
            if (len_reg < LW'(MAX_TOKEN)) begin
                len_next = len_reg + LW'(1);
                for (int k = 0; k < NUM_KW; k++) begin
                    match_next[k] = match_reg[k] && len_reg < LW'(KW_LEN[k]) &&
                                    kw_char(k, 6'(len_reg)) == c_reg;
                end
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    assign cur_last = len_reg == '0 || LW'(idx_reg) + LW'(1) == len_reg;

    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            ST_IDLE: if (s_tvalid) fsm_next = ST_STEP;
            ST_STEP: fsm_next = emit ? ST_RD : ST_IDLE;
            ST_RD:   fsm_next = ST_WT;
            ST_WT:   fsm_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    if (!o_last_reg) begin
                        fsm_next = ST_RD;
                    end else if (rescan_reg) begin
                        fsm_next = ST_STEP;
                    end else begin
                        fsm_next = ST_IDLE;
                    end
                end
            end
            default: fsm_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= ST_IDLE;
            sc_reg <= SC_START;
            len_reg <= '0;
            ovf_reg <= 1'b0;
            match_reg <= '1;
            line_reg <= LINE_BITS'(1);
            rescan_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            fsm_reg <= fsm_next;
            case (fsm_reg)
                ST_IDLE: begin
                    c_reg <= s_tdata;
                    eof_reg <= s_tlast;
                end
                ST_STEP: begin
                    sc_reg <= sc_next;
                    len_reg <= len_next;
                    ovf_reg <= ovf_next;
                    match_reg <= match_next;
                    kind_reg <= kind_next;
                    rescan_reg <= rescan_next;
                    idx_reg <= '0;
                    if (!emit && !eof_reg && c_reg == 8'h0A) begin
                        line_reg <= line_reg + LINE_BITS'(1);
                    end
                end
                ST_WT: begin
                    out_valid_reg <= 1'b1;
                    o_kind_reg <= kind_reg;
                    o_line_reg <= line_reg;
                    o_char_reg <= (len_reg == '0) ? 8'd0 : rdata;
                    o_cv_reg <= len_reg != '0;
                    o_tr_reg <= ovf_reg;
                    o_last_reg <= cur_last;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        idx_reg <= idx_reg + AW'(1);
                        if (o_last_reg) begin
                            len_reg <= '0;
                            ovf_reg <= 1'b0;
                            match_reg <= '1;
                            rescan_reg <= 1'b0;
                            if (!rescan_reg && !eof_reg && c_reg == 8'h0A) begin
                                line_reg <= line_reg + LINE_BITS'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = fsm_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'({o_tr_reg, o_cv_reg, o_char_reg, o_line_reg});
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
endmodule

>>> sv/plex_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module plex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/plex_checker.sv
// Port-level assertions for the lexer, bound to the top level.
module plex_checker
    import plex_pkg::*;
#(
    parameter int LINE_BITS = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [((LINE_BITS+10+7)/8)*8-1:0] m_tdata,
    input logic [5:0]           m_tuser,
    input logic                 m_tlast
);
    // The block never takes a byte while a token beat is on offer.
    a_no_accept_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input accepted while output pending");

    // An accepted byte is scanned before the next one can be taken.
    a_one_byte_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("back-to-back input accepted");

    // A beat without a character is always the whole token.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[LINE_BITS+8] |-> m_tlast)
        else $error("empty text beat is not last");

    // End-of-file tokens carry no text and no truncation.
    a_eof_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == K_EOF |-> !m_tdata[LINE_BITS+8] && !m_tdata[LINE_BITS+9])
        else $error("endfile token with text");

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast)) else $error("stalled output beat changed");
endmodule

bind pascal_subset_lexer_unit plex_checker #(.LINE_BITS(LINE_BITS)) u_plex_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/sv/pascal_subset_lexer_unit_test.sv
// Self-checking testbench of the Pascal subset lexer: directed table, then random source text.
`timescale 1ns / 1ps

module pascal_subset_lexer_unit_test;
    import plex_pkg::*;

    localparam int TOK_MAX   = 32;
    localparam int CYCLE_CAP = 400000;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [7:0]  ch;
        logic        valid;
        logic        trunc;
        logic        last;
    } token_beat_t;

    typedef struct {
        logic [7:0] ch;
        bit         eof;
        bit         has_kind;
        logic [5:0] kind;
    } src_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    pascal_subset_lexer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Scanner image kept by the testbench.
    scan_t       lex_state = SC_START;
    logic [7:0]  tok_text [TOK_MAX];
    int          tok_len = 0;
    bit          tok_ovf = 1'b0;
    logic [15:0] cur_line = 16'd1;

    token_beat_t token_q [$];
    src_row_t    src_q [$];
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          tokens_out = 0;
    int          step_count;
    logic [5:0]  step_first_kind;
    bit          hold_req = 1'b0;
    int          cycles = 0;

    string kw_words [NUM_KW] = '{
        "array", "begin", "char", "const", "do", "downto", "else", "end", "for",
        "function", "if", "integer", "uinteger", "of", "procedure", "read", "repeat",
        "then", "to", "until", "var", "write"
    };
    string sym_chars = ".+-*/=,;()[]}<>:";

    function automatic logic [5:0] ident_or_keyword();
        bit same;
        if (tok_ovf) return K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (kw_words[k].len() == tok_len) begin
                same = 1'b1;
                for (int i = 0; i < tok_len; i++)
                    if (tok_text[i] != kw_words[k][i]) same = 1'b0;
                if (same) return K_KW0 + 6'(k);
            end
        end
        return K_IDENT;
    endfunction

    function automatic void keep_char(logic [7:0] c);
        if (tok_len < TOK_MAX) begin
            tok_text[tok_len] = c;
            tok_len++;
        end else begin
            tok_ovf = 1'b1;
        end
    endfunction

    function automatic void finish_token(logic [5:0] kind);
        token_beat_t b;
        if (kind == K_IDENT) kind = ident_or_keyword();
        if (step_count == 0) step_first_kind = kind;
        b.kind  = kind;
        b.line  = cur_line;
        b.trunc = tok_ovf;
        if (tok_len == 0) begin
            b.ch = 8'd0; b.valid = 1'b0; b.last = 1'b1;
            token_q.push_back(b);
            step_count++;
        end else begin
            for (int i = 0; i < tok_len; i++) begin
                b.ch = tok_text[i]; b.valid = 1'b1; b.last = (i + 1 == tok_len);
                token_q.push_back(b);
                step_count++;
            end
        end
        tok_len = 0;
        tok_ovf = 1'b0;
        lex_state = SC_START;
    endfunction

    function automatic void drop_and_end();
        tok_len = 0;
        tok_ovf = 1'b0;
        finish_token(K_EOF);
    endfunction

    function automatic logic [5:0] single_kind_of(logic [7:0] c);
        for (int i = 0; i < 13; i++)
            if (sym_chars[i] == c) return K_DOT + 6'(i);
        return K_ERR;
    endfunction

    // Returns 1 when the byte terminated a token and must be scanned again.
    function automatic bit scan_byte(logic [7:0] c, bit eof);
        bit digit, alpha;
        digit = (c >= "0" && c <= "9");
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        case (lex_state)
            SC_CMT: begin
                if (eof) drop_and_end();
                else if (c == "}") lex_state = SC_START;
            end
            SC_STR: begin
                if (eof) drop_and_end();
                else if (c == "\"") finish_token(K_STR);
                else if (c >= 8'h20 && c <= 8'h7E) keep_char(c);
                else begin keep_char(c); finish_token(K_ERR); end
            end
            SC_CHR: begin
                if (eof) drop_and_end();
                else if (c == "'") finish_token(K_CHR);
                else keep_char(c);
            end
            SC_NUM: begin
                if (!eof && digit) keep_char(c);
                else begin finish_token(K_NUM); return 1'b1; end
            end
            SC_IDENT: begin
                if (!eof && (digit || alpha)) keep_char(c);
                else begin finish_token(K_IDENT); return 1'b1; end
            end
            SC_LT: begin
                if (!eof && c == "=") begin keep_char(c); finish_token(K_LEQ); end
                else if (!eof && c == ">") begin keep_char(c); finish_token(K_NEQ); end
                else begin finish_token(K_LT); return 1'b1; end
            end
            SC_COLON: begin
                if (!eof && c == "=") begin keep_char(c); finish_token(K_ASGN); end
                else begin finish_token(K_COLON); return 1'b1; end
            end
            SC_GT: begin
                if (!eof && c == "=") begin keep_char(c); finish_token(K_GEQ); end
                else begin finish_token(K_GT); return 1'b1; end
            end
            default: begin
                if (eof) drop_and_end();
                else if (c == " " || (c >= 8'd9 && c <= 8'd13)) ;
                else if (digit) begin keep_char(c); lex_state = SC_NUM; end
                else if (c == "\"") lex_state = SC_STR;
                else if (c == "'") lex_state = SC_CHR;
                else if (c == "{") lex_state = SC_CMT;
                else if (alpha) begin keep_char(c); lex_state = SC_IDENT; end
                else if (c == ":") begin keep_char(c); lex_state = SC_COLON; end
                else if (c == ">") begin keep_char(c); lex_state = SC_GT; end
                else if (c == "<") begin keep_char(c); lex_state = SC_LT; end
                else begin keep_char(c); finish_token(single_kind_of(c)); end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, bit eof);
        step_count = 0;
        if (scan_byte(c, eof)) void'(scan_byte(c, eof));
        if (!eof && c == 8'h0A) cur_line = cur_line + 16'd1;
    endfunction

    function automatic void add_src(logic [7:0] c, bit eof = 1'b0);
        src_row_t r;
        r.ch = c; r.eof = eof; r.has_kind = 1'b0; r.kind = K_EOF;
        src_q.push_back(r);
    endfunction

    function automatic void add_word(string w);
        for (int i = 0; i < w.len(); i++) add_src(w[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
    endfunction

    function automatic void add_fragment();
        int sel, n;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            add_src(rand_letter());
            n = $urandom_range(0, 7);
            repeat (n) add_src($urandom_range(0, 2) == 0 ? 8'($urandom_range(48, 57))
                                                         : rand_letter());
        end else if (sel < 25) begin
            add_word(kw_words[$urandom_range(0, NUM_KW - 1)]);
            add_src(" ");
        end else if (sel < 35) begin
            repeat ($urandom_range(1, 6)) add_src(8'($urandom_range(48, 57)));
        end else if (sel < 45) begin
            case ($urandom_range(0, 2))
                0: add_src(" ");
                1: add_src(8'h09);
                default: add_src(8'h0A);
            endcase
        end else if (sel < 60) begin
            add_src(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
            if ($urandom_range(0, 2) == 0) add_src($urandom_range(0, 1) ? "=" : ">");
        end else if (sel < 67) begin
            add_src("\"");
            n = $urandom_range(0, 6);
            repeat (n) begin
                c = 8'($urandom_range(32, 126));
                add_src(c == "\"" ? "x" : c);
            end
            if ($urandom_range(0, 9) == 0) add_src(8'($urandom_range(0, 1) ? 8'h7F : 8'h05));
            else add_src("\"");
        end else if (sel < 72) begin
            add_src("'");
            repeat ($urandom_range(0, 3)) begin
                c = 8'($urandom_range(0, 255));
                add_src(c == "'" ? 8'hA7 : c);
            end
            add_src("'");
        end else if (sel < 77) begin
            add_src("{");
            repeat ($urandom_range(0, 5)) begin
                c = 8'($urandom_range(0, 255));
                add_src(c == "}" ? "z" : c);
            end
            add_src("}");
        end else if (sel < 80) begin
            // Overlong text: the identifier or string can run past the buffer.
            if ($urandom_range(0, 1)) begin
                add_src(rand_letter());
                repeat ($urandom_range(30, 40)) add_src(rand_letter());
            end else begin
                add_src("\"");
                repeat ($urandom_range(31, 38)) add_src(8'($urandom_range(35, 126)));
                add_src("\"");
            end
        end else if (sel < 90) begin
            add_src(8'($urandom_range(0, 255)));
        end else if (sel < 93) begin
            add_src(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            add_src(8'h0A);
        end
    endfunction

    function automatic src_row_t row(logic [7:0] c, bit eof, bit chk, logic [5:0] k);
        src_row_t r;
        r.ch = c; r.eof = eof; r.has_kind = chk; r.kind = k;
        return r;
    endfunction

    int burst_left = 0;

    task automatic send_beat(src_row_t r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= r.ch;
        s_tlast  <= r.eof;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_tokens(r.ch, r.eof);
        beats_in++;
        if (r.has_kind && (step_count == 0 || step_first_kind != r.kind)) begin
            $error("directed row %0d: field token_kind expected %0d actual %0d",
                   beats_in, r.kind, step_count ? step_first_kind : 6'h3F);
            errors++;
        end
        @(negedge aclk);
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request.
    int rx_cycle = 0;
    initial begin
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 9) < 3);
                    default: m_tready <= (rx_cycle % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        token_beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (m_tlast) tokens_out++;
            if (token_q.size() == 0) begin
                $error("token beat with no expectation: kind %0d data %h", m_tuser, m_tdata);
                errors++;
            end else begin
                e = token_q.pop_front();
                if (m_tuser != e.kind) begin
                    $error("token_kind expected %0d actual %0d", e.kind, m_tuser); errors++;
                end
                if (m_tdata[15:0] != e.line) begin
                    $error("line_number expected %0d actual %0d", e.line, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[23:16] != e.ch) begin
                    $error("text_char expected %h actual %h", e.ch, m_tdata[23:16]); errors++;
                end
                if (m_tdata[24] != e.valid) begin
                    $error("char_valid expected %0d actual %0d", e.valid, m_tdata[24]); errors++;
                end
                if (m_tdata[25] != e.trunc) begin
                    $error("truncated expected %0d actual %0d", e.trunc, m_tdata[25]); errors++;
                end
                if (m_tdata[31:26] != 6'd0) begin
                    $error("tdata padding expected 0 actual %h", m_tdata[31:26]); errors++;
                end
                if (m_tlast != e.last) begin
                    $error("last expected %0d actual %0d", e.last, m_tlast); errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles, token_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        src_row_t dir_rows [$];
        dir_rows = '{
            row(8'h00, 1'b1, 1'b1, K_EOF),   // end of input at start: empty endfile
            row(8'h00, 1'b0, 1'b1, K_ERR),
            row(8'hFF, 1'b0, 1'b1, K_ERR),
            row("<", 1'b0, 1'b0, K_EOF), row("=", 1'b0, 1'b1, K_LEQ),
            row("<", 1'b0, 1'b0, K_EOF), row(">", 1'b0, 1'b1, K_NEQ),
            row(":", 1'b0, 1'b0, K_EOF), row("=", 1'b0, 1'b1, K_ASGN),
            row(">", 1'b0, 1'b0, K_EOF), row("=", 1'b0, 1'b1, K_GEQ),
            row(">", 1'b0, 1'b0, K_EOF), row("9", 1'b0, 1'b1, K_GT),
            row(";", 1'b0, 1'b1, K_NUM),     // one byte ends a number and a symbol
            row("\"", 1'b0, 1'b0, K_EOF), row("\"", 1'b0, 1'b1, K_STR),
            row("\"", 1'b0, 1'b0, K_EOF), row(8'h07, 1'b0, 1'b1, K_ERR),
            row("'", 1'b0, 1'b0, K_EOF), row(8'h80, 1'b0, 1'b0, K_EOF),
            row("'", 1'b0, 1'b1, K_CHR),
            row("{", 1'b0, 1'b0, K_EOF), row(8'h0A, 1'b0, 1'b0, K_EOF),
            row(8'h00, 1'b1, 1'b1, K_EOF),   // end of input inside a comment
            row("}", 1'b0, 1'b1, K_RBRC)
        };
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (dir_rows[i]) send_beat(dir_rows[i]);

        while (src_q.size() < 200) add_fragment();
        add_src(8'h00, 1'b1);
        foreach (src_q[i]) begin
            if (i == 40) hold_req = 1'b1;
            if (i == 120) begin
                s_tvalid <= 1'b0;
                burst_left = 1;
                wait (token_q.size() == 0);
                @(negedge aclk);
            end
            send_beat(src_q[i]);
        end
        s_tvalid <= 1'b0;

        wait (token_q.size() == 0 && !hold_req);
        repeat (40) @(posedge aclk);
        if (token_q.size() != 0) begin
            $error("%0d expected token beats never arrived", token_q.size());
            errors++;
        end
        $display("Scanned %0d source beats into %0d tokens (%0d text beats), last line %0d.",
                 beats_in, tokens_out, beats_out, cur_line);
        $display("Covered every symbol, keywords, literals, comments, overlong text, bad bytes.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
